>>> rtl/snt_pkg.sv
// shared constants, types and helper functions for the nibble trie map
package snt_pkg;

    localparam int NODES    = 1024;
    localparam int NODE_W   = $clog2(NODES);
    localparam int LEVELS   = 11;
    localparam int LVL_W    = 4;
    localparam int NIB_W    = 4;
    localparam int FANOUT   = 16;
    localparam int KEY_BITS = LEVELS * NIB_W;
    localparam int SLOT_AW  = NODE_W + NIB_W;
    localparam int FREE_W   = 11;
    localparam int IDX_W    = 8;

    typedef enum logic [1:0] {
        CMD_PUT,
        CMD_GET,
        CMD_REM,
        CMD_NONE
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_INVALID,
        ST_NOTFOUND,
        ST_POOL,
        ST_DUP
    } status_t;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_W_NODE,
        S_W_BMP,
        S_W_SLOT,
        S_A_RD,
        S_A_DAT,
        S_SH_RD,
        S_SH_WR,
        S_LINK,
        S_NEWLEAF,
        S_PUSH,
        S_D_RD,
        S_D_BMP,
        S_DS_RD,
        S_DS_WR,
        S_D_WR
    } state_t;

    typedef struct packed {
        logic [FANOUT-1:0] bm;
        logic              pv;
        logic [IDX_W-1:0]  pidx;
        logic [NODE_W-1:0] fs;
    } node_word_t;

    typedef struct packed {
        logic bm;
        logic pl;
        logic fs;
    } node_we_t;

    function automatic logic [4:0] pop16(input logic [FANOUT-1:0] v);
        logic [4:0] c;
        c = '0;
        for (int i = 0; i < FANOUT; i++)
        begin
            c = c + 5'(v[i]);
        end
        return c;
    endfunction

    function automatic logic [NIB_W-1:0] nib_of(input logic [KEY_BITS-1:0] k,
                                                input logic [LVL_W-1:0] d);
        logic [NIB_W-1:0] r;
        r = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (d == LVL_W'(l))
            begin
                r = k[(LEVELS-1-l)*NIB_W +: NIB_W];
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/sparse_nibble_trie_map.sv
// top level: command sequencer for the bitmap compressed 16-way trie
// get walks the key one nibble per level; put takes a node from the free stack for each
// missing level and shifts later child slots up; remove frees emptied nodes up the path
// one command at a time, accepted only in idle while busy is low; done pulses one cycle
// invalid commands answer on the cycle after start; results cannot be stalled
// after reset a pass initialises all 1024 node entries, busy stays high until it ends
module sparse_nibble_trie_map
    import snt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [47:0] key,
    input  logic [15:0] new_index,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  found_index,
    output logic [10:0] free_nodes
);

    localparam logic [NODE_W-1:0] ROOT = NODE_W'(NODES - 1);

    state_t state_reg, state_next;
    logic [NODE_W-1:0] clr_reg;
    logic [FREE_W-1:0] free_top_reg;
    logic              done_reg;
    status_t           status_reg;
    logic [IDX_W-1:0]  found_reg;

    cmd_t              cmd_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [LVL_W-1:0]  depth_reg;
    logic [NODE_W-1:0] cur_reg;
    logic [NODE_W-1:0] nn_reg;
    logic [FANOUT-1:0] bm_reg;
    logic [3:0]        sh_reg;
    logic [NODE_W-1:0] par_reg [LEVELS];

    node_we_t          node_we;
    logic [NODE_W-1:0] node_waddr, node_raddr;
    node_word_t        node_wdata, node_rdata;
    logic              slot_we;
    logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
    logic [NODE_W-1:0] slot_wdata, slot_rdata;

    logic [NIB_W-1:0]  nib;
    logic [FANOUT-1:0] bit_w, low_mask;
    logic [4:0]        pos_r, cnt_r, pos_m, cnt_m;
    logic              present, leaf, short_pool, bad_cmd;
    logic [FREE_W-1:0] missing;

    snt_node_ram u_node (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    snt_slot_ram u_slot (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign nib        = nib_of(key_reg, depth_reg);
    assign bit_w      = FANOUT'(1) << nib;
    assign low_mask   = bit_w - FANOUT'(1);
    assign pos_r      = pop16(bm_reg & low_mask);
    assign cnt_r      = pop16(bm_reg);
    assign pos_m      = pop16(node_rdata.bm & low_mask);
    assign cnt_m      = pop16(node_rdata.bm);
    assign present    = |(node_rdata.bm & bit_w);
    assign leaf       = (depth_reg == LVL_W'(LEVELS));
    assign missing    = FREE_W'(LVL_W'(LEVELS) - depth_reg);
    assign short_pool = (missing > free_top_reg);
    assign bad_cmd    = (key[47:KEY_BITS] != '0) || (cmd_t'(cmd) == CMD_NONE)
                     || ((cmd_t'(cmd) == CMD_PUT) && (new_index[15:IDX_W] != '0));

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign free_nodes  = free_top_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:     if (clr_reg == ROOT) state_next = S_IDLE;
            S_IDLE:    if (start && !bad_cmd) state_next = S_W_NODE;
            S_W_NODE:  state_next = S_W_BMP;
            S_W_BMP:
            begin
                if (leaf)
                    state_next = (cmd_reg == CMD_REM && node_rdata.pv) ? S_PUSH : S_IDLE;
                else if (present)
                    state_next = S_W_SLOT;
                else if (cmd_reg == CMD_PUT && !short_pool)
                    state_next = S_A_RD;
                else
                    state_next = S_IDLE;
            end
            S_W_SLOT:  state_next = S_W_NODE;
            S_A_RD:    state_next = S_A_DAT;
            S_A_DAT:   state_next = (cnt_r > pos_r) ? S_SH_RD : S_LINK;
            S_SH_RD:   state_next = S_SH_WR;
            S_SH_WR:   state_next = (5'(sh_reg) - 5'd1 == pos_r) ? S_LINK : S_SH_RD;
            S_LINK:    state_next = (depth_reg + LVL_W'(1) == LVL_W'(LEVELS)) ? S_NEWLEAF
                                                                            : S_A_RD;
            S_NEWLEAF: state_next = S_IDLE;
            S_PUSH:    state_next = S_D_RD;
            S_D_RD:    state_next = S_D_BMP;
            S_D_BMP:   state_next = (pos_m + 5'd1 < cnt_m) ? S_DS_RD : S_D_WR;
            S_DS_RD:   state_next = S_DS_WR;
            S_DS_WR:   state_next = (5'(sh_reg) + 5'd2 < cnt_r) ? S_DS_RD : S_D_WR;
            S_D_WR:    state_next = (((bm_reg & ~bit_w) == '0) && (depth_reg != '0))
                                    ? S_PUSH : S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // memory controls
    always_comb
    begin
        node_we    = '0;
        node_waddr = cur_reg;
        node_wdata = '0;
        node_raddr = cur_reg;
        slot_we    = 1'b0;
        slot_waddr = {cur_reg, sh_reg};
        slot_wdata = slot_rdata;
        slot_raddr = {cur_reg, pos_m[3:0]};
        unique case (state_reg)
            S_CLR:
            begin
                node_we       = '{bm: 1'b1, pl: 1'b1, fs: 1'b1};
                node_waddr    = clr_reg;
                node_wdata.fs = clr_reg;
            end
            S_W_BMP:
            begin
                if (leaf && cmd_reg == CMD_PUT)
                begin
                    node_we.pl      = 1'b1;
                    node_wdata.pv   = 1'b1;
                    node_wdata.pidx = idx_reg;
                end
                else if (leaf && cmd_reg == CMD_REM && node_rdata.pv)
                begin
                    node_we.pl = 1'b1;
                end
            end
            S_A_RD:    node_raddr = NODE_W'(free_top_reg - FREE_W'(1));
            S_SH_RD:   slot_raddr = {cur_reg, sh_reg - 4'd1};
            S_SH_WR:   slot_we = 1'b1;
            S_LINK:
            begin
                slot_we       = 1'b1;
                slot_waddr    = {cur_reg, pos_r[3:0]};
                slot_wdata    = nn_reg;
                node_we.bm    = 1'b1;
                node_wdata.bm = bm_reg | bit_w;
            end
            S_NEWLEAF:
            begin
                node_we.pl      = 1'b1;
                node_wdata.pv   = 1'b1;
                node_wdata.pidx = idx_reg;
            end
            S_PUSH:
            begin
                node_we.fs    = 1'b1;
                node_waddr    = free_top_reg[NODE_W-1:0];
                node_wdata.fs = cur_reg;
            end
            S_DS_RD:   slot_raddr = {cur_reg, sh_reg + 4'd1};
            S_DS_WR:   slot_we = 1'b1;
            S_D_WR:
            begin
                node_we.bm    = 1'b1;
                node_wdata.bm = bm_reg & ~bit_w;
            end
            default:
            begin
                node_we = '0;
            end
        endcase
    end

    // control state and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            free_top_reg <= FREE_W'(NODES - 1);
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
            found_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            found_reg <= '0;
            if (state_reg == S_CLR)
                clr_reg <= clr_reg + NODE_W'(1);
            if (state_reg == S_A_DAT)
                free_top_reg <= free_top_reg - FREE_W'(1);
            if (state_reg == S_PUSH)
                free_top_reg <= free_top_reg + FREE_W'(1);
            priority if (state_reg == S_IDLE && start && bad_cmd)
            begin
                done_reg   <= 1'b1;
                status_reg <= ST_INVALID;
            end
            else if (state_reg == S_W_BMP && leaf)
            begin
                if (cmd_reg == CMD_GET)
                begin
                    done_reg   <= 1'b1;
                    status_reg <= node_rdata.pv ? ST_OK : ST_NOTFOUND;
                    found_reg  <= node_rdata.pv ? node_rdata.pidx : '0;
                end
                else if (cmd_reg == CMD_PUT)
                begin
                    done_reg   <= 1'b1;
                    status_reg <= node_rdata.pv ? ST_DUP : ST_OK;
                end
                else if (!node_rdata.pv)
                begin
                    done_reg   <= 1'b1;
                    status_reg <= ST_NOTFOUND;
                end
            end
            else if (state_reg == S_W_BMP && !present)
            begin
                if (cmd_reg != CMD_PUT)
                begin
                    done_reg   <= 1'b1;
                    status_reg <= ST_NOTFOUND;
                end
                else if (short_pool)
                begin
                    done_reg   <= 1'b1;
                    status_reg <= ST_POOL;
                end
            end
            else if (state_reg == S_NEWLEAF
                     || (state_reg == S_D_WR && state_next == S_IDLE))
            begin
                done_reg   <= 1'b1;
                status_reg <= ST_OK;
            end
        end
    end

    // walk datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_reg   <= cmd_t'(cmd);
                key_reg   <= key[KEY_BITS-1:0];
                idx_reg   <= new_index[IDX_W-1:0];
                cur_reg   <= ROOT;
                depth_reg <= '0;
            end
            S_W_BMP:
            begin
                bm_reg <= node_rdata.bm;
                if (!leaf)
                    par_reg[depth_reg] <= cur_reg;
            end
            S_W_SLOT:
            begin
                cur_reg   <= slot_rdata;
                depth_reg <= depth_reg + LVL_W'(1);
            end
            S_A_DAT:
            begin
                nn_reg <= node_rdata.fs;
                sh_reg <= cnt_r[3:0];
            end
            S_SH_WR:   sh_reg <= sh_reg - 4'd1;
            S_LINK:
            begin
                cur_reg   <= nn_reg;
                bm_reg    <= '0;
                depth_reg <= depth_reg + LVL_W'(1);
            end
            S_PUSH:
            begin
                cur_reg   <= par_reg[depth_reg - LVL_W'(1)];
                depth_reg <= depth_reg - LVL_W'(1);
            end
            S_D_BMP:
            begin
                bm_reg <= node_rdata.bm;
                sh_reg <= pos_m[3:0];
            end
            S_DS_WR:   sh_reg <= sh_reg + 4'd1;
            default:
            begin
                sh_reg <= sh_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_top_reg <= FREE_W'(NODES))
        else $error("free stack pointer past pool size");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_OK) |-> (found_reg == '0))
        else $error("found index set on failed command");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_WR) |-> (5'(sh_reg) > pos_r))
        else $error("insert shift below insertion point");

    a_alloc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_RD) |-> (free_top_reg != '0))
        else $error("node pop from empty free stack");

    a_push_after_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |=> (free_top_reg == $past(free_top_reg) + FREE_W'(1)))
        else $error("free stack push lost");
`endif

endmodule

>>> rtl/snt_node_ram.sv
// node memory: child bitmap, payload and free stack entry, field write enables
module snt_node_ram
    import snt_pkg::*;
(
    input  logic              clk,
    input  node_we_t          we,
    input  logic [NODE_W-1:0] waddr,
    input  node_word_t        wdata,
    input  logic [NODE_W-1:0] raddr,
    output node_word_t        rdata
);

    node_word_t mem [NODES];

    always_ff @(posedge clk)
    begin
        if (we.bm)
        begin
            mem[waddr].bm <= wdata.bm;
        end
        if (we.pl)
        begin
            mem[waddr].pv   <= wdata.pv;
            mem[waddr].pidx <= wdata.pidx;
        end
        if (we.fs)
        begin
            mem[waddr].fs <= wdata.fs;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/snt_slot_ram.sv
// packed child list memory, one row of slots per node
module snt_slot_ram
    import snt_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [SLOT_AW-1:0] waddr,
    input  logic [NODE_W-1:0]  wdata,
    input  logic [SLOT_AW-1:0] raddr,
    output logic [NODE_W-1:0]  rdata
);

    logic [NODE_W-1:0] mem [NODES*FANOUT];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
